/* rtl/assert_macros.svh */
// Assertion macros used by the checker module of the rounding block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is checked during reset as well.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/dsdr_pkg.sv */
// Types, constants and power-of-ten tables for the significant-digit rounder.
package dsdr_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned DIG_W   = 4;
  localparam int unsigned POW_W   = 30;
  localparam int unsigned WORK_W  = 33;
  localparam int unsigned PROD_W  = 60;
  localparam int unsigned ADDR_W  = 3;

  localparam logic [DIG_W-1:0] SIGDIG_RESET = 4'd3;
  localparam logic [DIG_W-1:0] SIGDIG_MIN   = 4'd1;
  localparam logic [DIG_W-1:0] DROP_LAST    = 4'd1;

  // Register index, taken from paddr bit 2 (registers are word aligned).
  localparam logic REG_SIGDIG = 1'b0;

  // floor(x / 5) == (x * RECIP_FIVE) >> RECIP_SHIFT for every 32-bit x.
  localparam logic [31:0] RECIP_FIVE  = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 34;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             pass;
    logic [DIG_W-1:0] drop;
  } dsdr_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_OUT
  } dsdr_bk_state_t;

  function automatic logic [POW_W-1:0] pow10(input logic [DIG_W-1:0] e);
    logic [POW_W-1:0] p;
    unique case (e)
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

  // Half of ten to the e, for e from one to nine.
  function automatic logic [POW_W-1:0] half_pow10(input logic [DIG_W-1:0] e);
    logic [POW_W-1:0] h;
    unique case (e)
      4'd1:    h = 30'd5;
      4'd2:    h = 30'd50;
      4'd3:    h = 30'd500;
      4'd4:    h = 30'd5000;
      4'd5:    h = 30'd50000;
      4'd6:    h = 30'd500000;
      4'd7:    h = 30'd5000000;
      4'd8:    h = 30'd50000000;
      4'd9:    h = 30'd500000000;
      default: h = 30'd0;
    endcase
    return h;
  endfunction

  // Number of decimal digits of v, one for zero.
  function automatic logic [DIG_W-1:0] digit_count(input logic [VAL_W-1:0] v);
    logic [DIG_W-1:0] n;
    n = 4'd1;
    for (int k = 1; k <= 9; k++) begin
      if (v >= {2'b00, pow10(4'(k))}) n = n + 4'd1;
    end
    return n;
  endfunction

endpackage

/* rtl/dsdr_front.sv */
// Front end: takes a value, counts its digits and decides how many to drop.
module dsdr_front (
  input  logic                           start,
  input  logic                           full,
  input  logic [dsdr_pkg::VAL_W-1:0]     raw_value,
  input  logic [dsdr_pkg::DIG_W-1:0]     sig_digits,
  output logic                           push,
  output dsdr_pkg::dsdr_item_t           item
);
  import dsdr_pkg::*;

  logic [DIG_W-1:0] keep;
  logic [DIG_W-1:0] digits;

  always_comb begin
    keep   = (sig_digits < SIGDIG_MIN) ? SIGDIG_MIN : sig_digits;
    digits = digit_count(raw_value);
    push   = start & ~full;
    item.value = raw_value;
    item.pass  = (digits <= keep);
    // Only meaningful when digits are dropped.
    item.drop  = digits - keep;
  end

endmodule

/* rtl/dsdr_queue.sv */
// Two-entry queue between the classifying front end and the rounding back end.
module dsdr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dsdr_pkg::dsdr_item_t wr_item,
  input  logic                 pop,
  output dsdr_pkg::dsdr_item_t rd_item,
  output logic                 empty,
  output logic                 full
);
  import dsdr_pkg::*;

  dsdr_item_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    empty      = (cnt_r == '0);
    full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
    rd_item    = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

/* rtl/dsdr_back.sv */
// Back end: adds half the divisor, divides by ten per step, multiplies back.
module dsdr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        empty,
  input  dsdr_pkg::dsdr_item_t        item,
  output logic                        pop,
  output logic                        out_valid,
  output logic [dsdr_pkg::VAL_W-1:0]  out_rounded_value,
  output logic                        out_overflow
);
  import dsdr_pkg::*;

  dsdr_bk_state_t    state_r, state_nxt;
  logic [WORK_W-1:0] w_r, w_nxt;
  logic [DIG_W-1:0]  cnt_r, cnt_nxt;
  logic [POW_W-1:0]  d_r, d_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [63:0]       div_prod;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!empty) state_nxt = item.pass ? BK_OUT : BK_DIV;
      BK_DIV:  if (cnt_r == DROP_LAST) state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_OUT;
      BK_OUT:  state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop       = (state_r == BK_IDLE) && !empty;
    out_valid = (state_r == BK_OUT);
  end

  // Datapath. Rounding half up is floor((v + D/2) / D), and floor(x / 10)
  // is taken as floor(floor(x / 2) / 5) through a reciprocal multiply.
  always_comb begin
    div_prod = 64'(w_r[WORK_W-1:1]) * 64'(RECIP_FIVE);
    w_nxt    = w_r;
    cnt_nxt  = cnt_r;
    d_nxt    = d_r;
    prod_nxt = prod_r;
    unique case (state_r)
      BK_IDLE: begin
        w_nxt    = {1'b0, item.value} + {3'b000, half_pow10(item.drop)};
        cnt_nxt  = item.drop;
        d_nxt    = pow10(item.drop);
        prod_nxt = {{(PROD_W-VAL_W){1'b0}}, item.value};
      end
      BK_DIV: begin
        w_nxt   = {3'b000, div_prod[63:RECIP_SHIFT]};
        cnt_nxt = cnt_r - DIG_W'(1);
      end
      BK_MUL: begin
        prod_nxt = PROD_W'(w_r[POW_W-1:0]) * PROD_W'(d_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    cnt_r  <= cnt_nxt;
    d_r    <= d_nxt;
    prod_r <= prod_nxt;
  end

  always_comb begin
    out_overflow      = |prod_r[PROD_W-1:VAL_W];
    out_rounded_value = out_overflow ? '1 : prod_r[VAL_W-1:0];
  end

endmodule

/* rtl/decimal_significant_digit_round.sv */
// Accepted values pass through the queue to the back end, which works on one at a time.
// Idle leads to the result strobe, through the divide loop and multiply when digits are dropped.
// The front end accepts while the two-entry queue has room; busy is high only when it is full.
// The result strobe lasts one cycle and is never held off by the receiver.
// Synchronous active-low reset sets significant_digits to 3, empties the queue, idles the back.
module decimal_significant_digit_round (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dsdr_pkg::VAL_W-1:0]    in_raw_value,
  output logic                          out_valid,
  output logic [dsdr_pkg::VAL_W-1:0]    out_rounded_value,
  output logic                          out_overflow,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dsdr_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import dsdr_pkg::*;

  logic [DIG_W-1:0] sig_r, sig_nxt;
  logic             cfg_wr;
  logic             push, pop, empty, full;
  dsdr_item_t       wr_item, rd_item;

  always_comb begin
    pready  = 1'b1;
    cfg_wr  = psel & penable & pwrite & pready & (paddr[2] == REG_SIGDIG);
    sig_nxt = cfg_wr ? pwdata[DIG_W-1:0] : sig_r;
    prdata  = (paddr[2] == REG_SIGDIG) ? {{(32-DIG_W){1'b0}}, sig_r} : '0;
    busy    = full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_r <= SIGDIG_RESET;
    end else begin
      sig_r <= sig_nxt;
    end
  end

  dsdr_front u_front (
    .start      (start),
    .full       (full),
    .raw_value  (in_raw_value),
    .sig_digits (sig_r),
    .push       (push),
    .item       (wr_item)
  );

  dsdr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .empty   (empty),
    .full    (full)
  );

  dsdr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .empty             (empty),
    .item              (rd_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_rounded_value (out_rounded_value),
    .out_overflow      (out_overflow)
  );

endmodule

/* rtl/dsdr_checker.sv */
// Port-level checks for the significant-digit rounder, bound to its top level.
`include "assert_macros.svh"

module dsdr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        busy,
  input logic                        out_valid,
  input logic [dsdr_pkg::VAL_W-1:0]  out_rounded_value,
  input logic                        out_overflow
);
  import dsdr_pkg::*;

  // After every result the back end returns to idle before it can give the next one.
  `ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  // A saturated result always carries the all-ones value.
  `ASSERT_SAME(a_sat_value, clk, rst_n, out_valid && out_overflow, out_rounded_value == '1)
  // Reset empties the queue, so the block is ready right after it.
  `ASSERT_NEXT_ALWAYS(a_ready_after_reset, clk, !rst_n, !busy)
  // Reset leaves no result pending.
  `ASSERT_NEXT_ALWAYS(a_quiet_after_reset, clk, !rst_n, !out_valid)

endmodule

bind decimal_significant_digit_round dsdr_checker u_dsdr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_rounded_value (out_rounded_value),
  .out_overflow      (out_overflow)
);
